// File: rtl/decimal_display_frame_encoder_macros.svh
// assertion macros for the display frame encoder
`ifndef DECIMAL_DISPLAY_FRAME_ENCODER_MACROS_SVH
`define DECIMAL_DISPLAY_FRAME_ENCODER_MACROS_SVH
`ifndef SYNTHESIS
// property checked outside reset
`define DDFE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// property checked on every edge, reset included
`define DDFE_ASSERT_ANY(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DDFE_ASSERT(lbl, clk, rst_n, prop, msg)
`define DDFE_ASSERT_ANY(lbl, clk, prop, msg)
`endif
`endif

// File: rtl/ddfe_pkg.sv
// shared types, constants and glyph table of the display frame encoder
`timescale 1ns / 1ps
package ddfe_pkg;

    // input value width and display positions
    localparam int VAL_W    = 27;
    localparam int POS      = 8;
    // shift-and-adjust steps done in one conversion stage
    localparam int DD_STEPS = 7;

    // beat counter over the 19-byte frame
    localparam int CNT_W = 5;
    localparam logic [CNT_W-1:0] BEAT_DISPLAY = 5'd0;
    localparam logic [CNT_W-1:0] BEAT_DATA    = 5'd1;
    localparam logic [CNT_W-1:0] BEAT_ADDR    = 5'd2;
    localparam logic [CNT_W-1:0] BEAT_SEG0    = 5'd3;
    localparam logic [CNT_W-1:0] BEAT_LAST    = 5'd18;

    // driver command and data bytes
    localparam logic [7:0] CMD_DISPLAY = 8'h88;
    localparam logic [7:0] CMD_DATA    = 8'h40;
    localparam logic [7:0] CMD_ADDR    = 8'hC0;
    localparam logic [7:0] LED_FIRST   = 8'h80;
    localparam logic [7:0] LED_OFF     = 8'h00;

    // configuration registers
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLANK      = 1'b1;
    localparam logic [2:0] BRIGHT_RESET = 3'd2;

    // position blanked in blank mode (fourth from the left)
    localparam int BLANK_POS = 4;

    typedef struct packed {
        logic [2:0] brightness;
        logic       blank_fourth;
    } t_cfg;

    // segment byte k, bit j from position of weight 10^j
    typedef logic [POS-1:0][7:0] t_seg;

    // seven-segment glyph of one decimal digit
    function automatic logic [7:0] glyph_of(input logic [3:0] d);
        logic [7:0] g;
        case (d)
            4'd0:    g = 8'h3F;
            4'd1:    g = 8'h06;
            4'd2:    g = 8'h5B;
            4'd3:    g = 8'h4F;
            4'd4:    g = 8'h66;
            4'd5:    g = 8'h6D;
            4'd6:    g = 8'h7D;
            4'd7:    g = 8'h07;
            4'd8:    g = 8'h7F;
            4'd9:    g = 8'h6F;
            default: g = 8'h00;
        endcase
        return g;
    endfunction

endpackage

// File: rtl/ddfe_dabble.sv
// one pipeline stage of the binary to decimal shift-and-add-3 conversion
`timescale 1ns / 1ps
module ddfe_dabble
    import ddfe_pkg::*;
#(
    parameter int BCD_W = 32,
    parameter int STEPS = 7
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [BCD_W-1:0] i_bcd,
    input  logic [VAL_W-1:0] i_bin,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [BCD_W-1:0] o_bcd,
    output logic [VAL_W-1:0] o_bin
);

    logic             r_valid;
    logic [BCD_W-1:0] r_bcd, n_bcd;
    logic [VAL_W-1:0] r_bin, n_bin;

    // adjust digits of five or more, then shift in the next binary bit
    always_comb begin
        n_bcd = i_bcd;
        n_bin = i_bin;
        for (int s = 0; s < STEPS; s++) begin
            for (int d = 0; d < BCD_W / 4; d++) begin
                if (n_bcd[4*d +: 4] >= 4'd5) begin
                    n_bcd[4*d +: 4] = n_bcd[4*d +: 4] + 4'd3;
                end
            end
            {n_bcd, n_bin} = {n_bcd[BCD_W-2:0], n_bin, 1'b0};
        end
    end

    // stage holds while its beat waits downstream
    assign o_stall = r_valid && i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_bcd <= n_bcd;
            r_bin <= n_bin;
        end
    end

    assign o_valid = r_valid;
    assign o_bcd   = r_bcd;
    assign o_bin   = r_bin;

endmodule

// File: rtl/ddfe_glyph.sv
// glyph lookup, fourth-digit blanking and segment transpose stage
`timescale 1ns / 1ps
module ddfe_glyph
    import ddfe_pkg::*;
#(
    parameter int DIGITS = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [4*DIGITS-1:0] i_bcd,
    input  t_cfg                i_cfg,
    output logic                o_valid,
    input  logic                i_stall,
    output t_seg                o_seg
);

    logic [POS-1:0][7:0] w_glyph;
    logic [POS-1:0][7:0] w_shown;
    logic                r_valid;
    t_seg                r_seg, n_seg;

    // glyph per position, unused positions dark
    for (genvar j = 0; j < POS; j++) begin : g_pos
        if (j < DIGITS) begin : g_used
            assign w_glyph[j] = glyph_of(i_bcd[4*j +: 4]);
        end else begin : g_dark
            assign w_glyph[j] = 8'h00;
        end
    end

    // blank mode and transpose into segment bytes
    always_comb begin
        w_shown = w_glyph;
        if (i_cfg.blank_fourth) begin
            w_shown[BLANK_POS] = 8'h00;
        end
        for (int k = 0; k < 8; k++) begin
            for (int j = 0; j < POS; j++) begin
                n_seg[k][j] = w_shown[j][k];
            end
        end
    end

    assign o_stall = r_valid && i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_seg <= n_seg;
        end
    end

    assign o_valid = r_valid;
    assign o_seg   = r_seg;

endmodule

// File: rtl/ddfe_serializer.sv
// frame serializer: one driver byte per beat, 19 beats per number
`timescale 1ns / 1ps
module ddfe_serializer
    import ddfe_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  t_seg       i_seg,
    input  t_cfg       i_cfg,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_strobe_release,
    output logic       o_last
);

    logic             r_valid;
    logic [CNT_W-1:0] r_cnt;
    t_seg             r_seg;
    logic             w_done;
    logic             w_load;
    logic [CNT_W-1:0] w_off;

    // final beat taken frees the frame register
    assign w_done  = r_valid && !i_stall && (r_cnt == BEAT_LAST);
    assign w_load  = !r_valid || w_done;
    assign o_stall = !w_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_cnt   <= BEAT_DISPLAY;
        end else if (w_load) begin
            r_valid <= i_valid;
            r_cnt   <= BEAT_DISPLAY;
        end else if (!i_stall) begin
            r_cnt   <= r_cnt + 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_seg <= i_seg;
        end
    end

    // byte select: three commands, then segment and led bytes in turn
    assign w_off = r_cnt - BEAT_SEG0;

    always_comb begin
        case (r_cnt)
            BEAT_DISPLAY: o_out_byte = CMD_DISPLAY | {5'b00000, i_cfg.brightness};
            BEAT_DATA:    o_out_byte = CMD_DATA;
            BEAT_ADDR:    o_out_byte = CMD_ADDR;
            default: begin
                if (!w_off[0]) begin
                    o_out_byte = r_seg[w_off[3:1]];
                end else if (w_off[3:1] == 3'd0) begin
                    o_out_byte = LED_FIRST;
                end else begin
                    o_out_byte = LED_OFF;
                end
            end
        endcase
    end

    assign o_strobe_release = (r_cnt == BEAT_DISPLAY) || (r_cnt == BEAT_DATA)
                              || (r_cnt == BEAT_LAST);
    assign o_last  = (r_cnt == BEAT_LAST);
    assign o_valid = r_valid;

endmodule

// File: rtl/decimal_display_frame_encoder.sv
// top level: number in, seven-segment driver frame out
//
//  channel  handshake          payload
//  in       i_valid / o_stall  i_value[26:0]
//  out      o_valid / i_stall  o_out_byte[7:0], o_strobe_release, o_last
//  cfg      i_cfg_we           i_cfg_index, i_cfg_data[2:0]
//
// each number gives 19 output beats, one a cycle while i_stall is low; the
// serializer's single byte output sets the sustained rate, and it loads the
// next number as the last beat is taken. from accept to first byte a number
// passes the clamp register, four conversion stages, glyph stage, serializer.
// reset clears all valid bits, sets brightness to 2 and blank mode off.
// i_stall freezes the current byte; back pressure reaches o_stall the same cycle.
`timescale 1ns / 1ps
`include "decimal_display_frame_encoder_macros.svh"
module decimal_display_frame_encoder
    import ddfe_pkg::*;
#(
    parameter int DIGITS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [VAL_W-1:0]     i_value,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [7:0]           o_out_byte,
    output logic                 o_strobe_release,
    output logic                 o_last,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int BCD_W = 4 * DIGITS;
    localparam logic [VAL_W-1:0] LIMIT = VAL_W'(10 ** DIGITS - 1);
    localparam int NSTG = (VAL_W + DD_STEPS - 1) / DD_STEPS;

    t_cfg             r_cfg;
    logic             r_in_valid;
    logic [VAL_W-1:0] r_clamp;

    logic             w_valid [NSTG+1];
    logic             w_stall [NSTG+1];
    logic [BCD_W-1:0] w_bcd   [NSTG+1];
    logic [VAL_W-1:0] w_bin   [NSTG+1];

    logic             w_seg_valid;
    logic             w_seg_stall;
    t_seg             w_seg;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.brightness   <= BRIGHT_RESET;
            r_cfg.blank_fourth <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_BRIGHTNESS: r_cfg.brightness   <= i_cfg_data[2:0];
                CFG_BLANK:      r_cfg.blank_fourth <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // input register with clamp to the largest shown value
    assign o_stall = r_in_valid && w_stall[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_clamp <= (i_value > LIMIT) ? LIMIT : i_value;
        end
    end

    assign w_valid[0] = r_in_valid;
    assign w_bcd[0]   = '0;
    assign w_bin[0]   = r_clamp;

    // conversion pipeline
    for (genvar s = 0; s < NSTG; s++) begin : g_dd
        localparam int LEFT  = VAL_W - s * DD_STEPS;
        localparam int STEPS = (LEFT < DD_STEPS) ? LEFT : DD_STEPS;
        ddfe_dabble #(
            .BCD_W (BCD_W),
            .STEPS (STEPS)
        ) u_dabble (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[s]),
            .o_stall (w_stall[s]),
            .i_bcd   (w_bcd[s]),
            .i_bin   (w_bin[s]),
            .o_valid (w_valid[s+1]),
            .i_stall (w_stall[s+1]),
            .o_bcd   (w_bcd[s+1]),
            .o_bin   (w_bin[s+1])
        );
    end

    // glyph and transpose stage
    ddfe_glyph #(
        .DIGITS (DIGITS)
    ) u_glyph (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid[NSTG]),
        .o_stall (w_stall[NSTG]),
        .i_bcd   (w_bcd[NSTG]),
        .i_cfg   (r_cfg),
        .o_valid (w_seg_valid),
        .i_stall (w_seg_stall),
        .o_seg   (w_seg)
    );

    // frame output
    ddfe_serializer u_serializer (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (w_seg_valid),
        .o_stall          (w_seg_stall),
        .i_seg            (w_seg),
        .i_cfg            (r_cfg),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_out_byte       (o_out_byte),
        .o_strobe_release (o_strobe_release),
        .o_last           (o_last)
    );

    // checks
    `DDFE_ASSERT(a_frame_unbroken, i_clk, i_rst_n,
        o_valid && !i_stall && !o_last |=> o_valid,
        "frame broke off before its last beat")
    `DDFE_ASSERT(a_frame_restart, i_clk, i_rst_n,
        o_valid && !i_stall && o_last |=> !o_valid || o_out_byte[7:3] == CMD_DISPLAY[7:3],
        "frame did not restart with display command")
    `DDFE_ASSERT_ANY(a_reset_out, i_clk, !i_rst_n |=> !o_valid, "output valid after reset")
    `DDFE_ASSERT_ANY(a_reset_in, i_clk, !i_rst_n |=> !o_stall, "input stalled after reset")

endmodule
